// ===== rtl/icmp_session_tracker_defines.svh =====
// Assertion macros for the ICMP session tracker checker
`ifndef ICMP_SESSION_TRACKER_DEFINES_SVH
`define ICMP_SESSION_TRACKER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define IST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define IST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/ist_pkg.sv =====
// Package for the ICMP session tracker: types, codes and helpers
package ist_pkg;
	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_REPLY   = 2'd1,
		KIND_QUENCH  = 2'd2,
		KIND_BLOCKED = 2'd3
	} kind_t;

	localparam logic [2:0] RSN_NON_ICMP  = 3'd0;
	localparam logic [2:0] RSN_BLOCKED   = 3'd1;
	localparam logic [2:0] RSN_REFRESHED = 3'd2;
	localparam logic [2:0] RSN_NEW_PAIR  = 3'd3;
	localparam logic [2:0] RSN_QUENCH    = 3'd4;
	localparam logic [2:0] RSN_RULE_DENY = 3'd5;
	localparam logic [2:0] RSN_NO_MATCH  = 3'd6;
	localparam logic [2:0] RSN_FULL      = 3'd7;

	localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
	localparam logic [0:0]  REG_TIMEOUT   = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DECIDE,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_idx;
		logic step;
		logic decide;
		logic fast;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_idx;
		logic need_sweep;
	} sts_t;

	function automatic kind_t classify(input logic [7:0] t, input logic [7:0] c);
		kind_t k;
		case (t)
			8'd0:    k = KIND_REPLY;
			8'd3:    k = (c <= 8'd5) ? KIND_REQUEST : KIND_BLOCKED;
			8'd4:    k = KIND_QUENCH;
			8'd8:    k = KIND_REQUEST;
			8'd11:   k = (c == 8'd0) ? KIND_REQUEST : KIND_BLOCKED;
			default: k = KIND_BLOCKED;
		endcase
		return k;
	endfunction
endpackage

// ===== rtl/ist_ctrl.sv =====
// Controller state machine: sequences one item at a time through the table scan or the fast path
module ist_ctrl import ist_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_rdy,
	output logic out_vld
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire) state_d = sts.need_sweep ? ST_SCAN : ST_OUT;
			ST_SCAN:   if (sts.last_idx) state_d = ST_WAIT;
			ST_WAIT:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_OUT;
			ST_OUT:    if (out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				cmd.load = in_fire;
				cmd.clr_idx = 1'b1;
				cmd.fast = in_fire && !sts.need_sweep;
			end
			ST_SCAN:   cmd.step = 1'b1;
			ST_WAIT:   cmd.step = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_OUT:    out_vld = 1'b1;
			default:   cmd = '0;
		endcase
	end
endmodule

// ===== rtl/ist_dp.sv =====
// Datapath: pair table, expiry sweep, lookup and verdict
module ist_dp import ist_pkg::*; #(
	parameter int unsigned TABLE_PAIRS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        is_icmp,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [7:0]  icmp_type,
	input  logic [7:0]  icmp_code,
	input  logic        rule_permits,
	input  logic [31:0] now,
	input  logic [31:0] timeout_ticks,
	output logic        verdict,
	output logic [2:0]  reason,
	output logic [6:0]  expired_pairs
);
	localparam int IW = (TABLE_PAIRS > 1) ? $clog2(TABLE_PAIRS) : 1;
	localparam int CW = $clog2(TABLE_PAIRS + 1);
	localparam logic [IW-1:0] LAST = IW'(TABLE_PAIRS - 1);

	// table memories; valid bits in flops
	logic [31:0] init_mem [TABLE_PAIRS];
	logic [31:0] resp_mem [TABLE_PAIRS];
	logic [31:0] seen_mem [TABLE_PAIRS];
	logic [TABLE_PAIRS-1:0] valid_q;

	logic [31:0] src_q, dst_q, now_q;
	logic        permits_q;
	kind_t       kind_q, kind_in;
	logic [IW-1:0] idx_q, idx_s1;
	logic        rd_s1;
	logic [31:0] init_s1, resp_s1, seen_s1;
	logic        match_q, free_q;
	logic [IW-1:0] match_idx_q, free_idx_q;
	logic [CW-1:0] exp_cnt_q;

	assign kind_in = classify(icmp_type, icmp_code);
	assign sts.need_sweep = is_icmp && (kind_in != KIND_BLOCKED);
	assign sts.last_idx = (idx_q == LAST);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q <= src_ip;
			dst_q <= dst_ip;
			now_q <= now;
			permits_q <= rule_permits;
			kind_q <= kind_in;
		end
	end

	// scan index and registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.step && !sts.last_idx) idx_q <= idx_q + 1'b1;
			rd_s1 <= cmd.step && !(rd_s1 && idx_s1 == LAST);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		init_s1 <= init_mem[idx_q];
		resp_s1 <= resp_mem[idx_q];
		seen_s1 <= seen_mem[idx_q];
	end

	// per-entry evaluation of the read stage
	logic ent_v, ent_exp, ent_hit;
	logic [31:0] want_i, want_r;
	assign want_i = (kind_q == KIND_REPLY) ? dst_q : src_q;
	assign want_r = (kind_q == KIND_REPLY) ? src_q : dst_q;
	assign ent_v = valid_q[idx_s1];
	assign ent_exp = ent_v && ((now_q - seen_s1) >= timeout_ticks);
	assign ent_hit = ent_v && !ent_exp && (init_s1 == want_i) && (resp_s1 == want_r);

	// sweep, search and final update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			match_q <= 1'b0;
			free_q <= 1'b0;
			exp_cnt_q <= '0;
			match_idx_q <= '0;
			free_idx_q <= '0;
			verdict <= 1'b0;
			reason <= RSN_NON_ICMP;
			expired_pairs <= '0;
		end else begin
			if (cmd.load) begin
				match_q <= 1'b0;
				free_q <= 1'b0;
				exp_cnt_q <= '0;
			end
			if (cmd.fast) begin
				verdict <= !is_icmp;
				reason <= is_icmp ? RSN_BLOCKED : RSN_NON_ICMP;
				expired_pairs <= '0;
			end
			if (rd_s1) begin
				if (ent_exp) begin
					valid_q[idx_s1] <= 1'b0;
					exp_cnt_q <= exp_cnt_q + 1'b1;
				end
				if (ent_hit && !match_q) begin
					match_q <= 1'b1;
					match_idx_q <= idx_s1;
				end
				if ((!ent_v || ent_exp) && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			if (cmd.decide) begin
				expired_pairs <= (exp_cnt_q > CW'(127)) ? 7'd127 : 7'(exp_cnt_q);
				if (kind_q == KIND_QUENCH) begin
					verdict <= 1'b1;
					reason <= RSN_QUENCH;
				end else if (match_q) begin
					verdict <= 1'b1;
					reason <= RSN_REFRESHED;
				end else if (kind_q == KIND_REPLY) begin
					verdict <= 1'b0;
					reason <= RSN_NO_MATCH;
				end else if (!permits_q) begin
					verdict <= 1'b0;
					reason <= RSN_RULE_DENY;
				end else if (!free_q) begin
					verdict <= 1'b0;
					reason <= RSN_FULL;
				end else begin
					verdict <= 1'b1;
					reason <= RSN_NEW_PAIR;
					valid_q[free_idx_q] <= 1'b1;
				end
			end
		end
	end

	// single memory write port: refresh or insert
	logic wr_en;
	logic [IW-1:0] wr_idx;
	assign wr_en = cmd.decide && (kind_q != KIND_QUENCH) &&
		(match_q || (kind_q == KIND_REQUEST && permits_q && free_q));
	assign wr_idx = match_q ? match_idx_q : free_idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seen_mem[wr_idx] <= now_q;
			if (!match_q) begin
				init_mem[wr_idx] <= src_q;
				resp_mem[wr_idx] <= dst_q;
			end
		end
	end
endmodule

// ===== rtl/icmp_session_tracker.sv =====
// ICMP session tracker top level: streams, APB register and submodules
// Swept ICMP items pass through the scan, wait and decide states before the result
//   is offered; non-ICMP or blocked items go straight to the output state. One item
//   is in flight at a time; the scan reads one table entry per cycle through a single
//   read port.
// Reset: arst_n clears all valid bits at once; timeout_ticks returns to 10000.
module icmp_session_tracker import ist_pkg::*; #(
	parameter int unsigned TABLE_PAIRS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// is_icmp[0], src_ip[32:1], dst_ip[64:33], icmp_type[72:65],
	// icmp_code[80:73], rule_permits[81], now[113:82], zero pad
	input  logic [119:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// verdict[0], reason[3:1], expired_pairs[10:4], zero pad
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cmd_t cmd;
	sts_t sts;
	logic [31:0] timeout_q;
	logic verdict;
	logic [2:0] reason;
	logic [6:0] expired_pairs;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == REG_TIMEOUT) ? timeout_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= TIMEOUT_RESET;
		else if (psel && penable && pwrite && paddr == REG_TIMEOUT) timeout_q <= pwdata;
	end

	ist_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
		.sts(sts), .cmd(cmd), .in_rdy(s_tready), .out_vld(m_tvalid)
	);

	ist_dp #(.TABLE_PAIRS(TABLE_PAIRS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.is_icmp(s_tdata[0]), .src_ip(s_tdata[32:1]), .dst_ip(s_tdata[64:33]),
		.icmp_type(s_tdata[72:65]), .icmp_code(s_tdata[80:73]),
		.rule_permits(s_tdata[81]), .now(s_tdata[113:82]),
		.timeout_ticks(timeout_q),
		.verdict(verdict), .reason(reason), .expired_pairs(expired_pairs)
	);

	assign m_tdata = {5'd0, expired_pairs, reason, verdict};
endmodule

// ===== rtl/ist_checker.sv =====
// Port-level checker for the ICMP session tracker, bound to the top level
`include "icmp_session_tracker_defines.svh"
module ist_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	`IST_ASSERT_IMP(a_one_in_flight, clk, arst_n, m_tvalid, !s_tready)
	`IST_ASSERT_NEXT(a_accept_closes, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`IST_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[15:11] == 5'd0)
	`IST_ASSERT_IMP(a_reason_verdict, clk, arst_n,
		m_tvalid && (m_tdata[3:1] == 3'd0 || m_tdata[3:1] == 3'd2), m_tdata[0])
	`IST_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind icmp_session_tracker ist_checker u_ist_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
